// ===== rtl/gln_pkg.sv =====
// ----------------------------------------------------------------------------
// gln_pkg: shared types and constants of the Gauss-Legendre node generator
// Fixed-point constants (Q30 in 64 bits), sequencer and divider states,
// and helpers used by the arithmetic units and the sequencer.
// ----------------------------------------------------------------------------
package gln_pkg;

   // default sizes
   localparam int N_MAX_DEF      = 64;
   localparam int MAX_NEWTON_DEF = 8;

   // q30 constants
   localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
   localparam logic signed [63:0] ZMAX     = 64'sd1073741823;
   localparam logic signed [63:0] PVAL_LIM = 64'sd1099511627776;
   localparam logic signed [63:0] OUT_MAX  = 64'sd140737488355327;
   localparam logic [63:0]        SAT_MAG  = 64'h4000_0000_0000_0000;
   localparam logic [31:0]        PI_Q30   = 32'd3373259426;

   // taylor coefficients of the cosine guess, constant term first
   localparam logic [31:0] COS_COEF [7] = '{
      32'd1073741824, 32'd536870912, 32'd44739243, 32'd1491308,
      32'd26631, 32'd296, 32'd2
   };

   // quotient lengths of the two divider modes
   localparam logic [5:0] DIVR_BITS = 6'd49;
   localparam logic [5:0] Q30_BITS  = 6'd62;

   typedef enum logic [4:0] {
      S_IDLE, S_TH, S_T2, S_COS, S_PINIT, S_RMUL, S_RDIV, S_NUM, S_ZZ,
      S_PP, S_DZ, S_E, S_W, S_OFF, S_WLO, S_WHI, S_ORD, S_OSEND
   } gln_state_type;

   typedef enum logic {
      DIV_ROUND,
      DIV_Q30
   } gln_div_mode_type;

   typedef enum logic [1:0] {
      D_IDLE, D_SETUP, D_ITER, D_DONE
   } gln_div_state_type;

   // magnitude of a signed 64-bit value
   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   // symmetric clamp to [-lim, lim]
   function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
      if (v > lim)
         clamp64 = lim;
      else if (v < -lim)
         clamp64 = -lim;
      else
         clamp64 = v;
   endfunction

endpackage

// ===== rtl/gln_mul.sv =====
// ----------------------------------------------------------------------------
// gln_mul: shared q30 multiplier
// Signed 64 x 64 product built in sequence from four 32 x 32 partial
// products, rounded to nearest and saturated at magnitude 2^62.
// ----------------------------------------------------------------------------
module gln_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   output logic               done,
   output logic signed [63:0] result
);

   localparam logic [63:0] SAT_MAG_L = gln_pkg::SAT_MAG;

   logic               busy_ff, busy_in;
   logic [2:0]         step_ff, step_in;
   logic [63:0]        ua_ff, ua_in, ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [63:0]        prod_ff, prod_in;
   logic [1:0]         psh_ff, psh_in;
   logic [127:0]       acc_ff, acc_in;
   logic               done_ff, done_in;
   logic signed [63:0] result_ff, result_in;

   logic [31:0]  half_a, half_b;
   logic [127:0] rnd;
   logic [63:0]  mag;

   assign half_a = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign half_b = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];

   // rounding and saturation of the accumulated product
   assign rnd = acc_ff + 128'd536870912;
   assign mag = (|rnd[127:92]) ? SAT_MAG_L : {2'b00, rnd[91:30]};

   // partial product sequence
   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      psh_in    = psh_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         ua_in   = gln_pkg::mag64(op_a);
         ub_in   = gln_pkg::mag64(op_b);
         neg_in  = op_a[63] ^ op_b[63];
         step_in = 3'd0;
         busy_in = 1'b1;
         acc_in  = 128'd0;
      end else if (busy_ff) begin
         if (step_ff <= 3'd3) begin
            prod_in = half_a * half_b;
            psh_in  = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
            acc_in = acc_ff + ({64'd0, prod_ff} << {psh_ff, 5'd0});
         end
         if (step_ff == 3'd5) begin
            result_in = neg_ff ? -$signed(mag) : $signed(mag);
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      psh_ff    <= psh_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/gln_div.sv =====
// ----------------------------------------------------------------------------
// gln_div: shared bit-serial divider
// Restoring division, one quotient bit per cycle. Rounded integer mode for
// small divisors and q30 mode with saturation at 2^62 and zero on a zero
// divisor.
// ----------------------------------------------------------------------------
module gln_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  gln_pkg::gln_div_mode_type mode,
   input  logic signed [63:0]        op_a,
   input  logic signed [63:0]        op_b,
   output logic                      done,
   output logic signed [63:0]        result
);

   gln_pkg::gln_div_state_type dstate_ff, dstate_in;
   gln_pkg::gln_div_mode_type  mode_ff, mode_in;
   logic signed [63:0] a_ff, a_in, b_ff, b_in;
   logic               neg_ff, neg_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        src_ff, src_in;
   logic [63:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               spec_ff, spec_in;
   logic [63:0]        smag_ff, smag_in;
   logic               done_ff, done_in;
   logic signed [63:0] result_ff, result_in;

   logic [63:0] ua, ub, nsum, fmag;
   logic [64:0] rem_sh, rem_sub;
   logic        ge;

   assign ua      = gln_pkg::mag64(a_ff);
   assign ub      = gln_pkg::mag64(b_ff);
   assign nsum    = ua + {1'b0, ub[63:1]};
   assign rem_sh  = {rem_ff, src_ff[63]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = (rem_sh >= {1'b0, den_ff});

   // final magnitude: q30 mode halves the quotient with rounding
   always_comb begin
      if (spec_ff)
         fmag = smag_ff;
      else if (mode_ff == gln_pkg::DIV_Q30)
         fmag = (quo_ff + 64'd1) >> 1;
      else
         fmag = quo_ff;
   end

   // divider sequence
   always_comb begin
      dstate_in = dstate_ff;
      mode_in   = mode_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      src_in    = src_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      spec_in   = spec_ff;
      smag_in   = smag_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (dstate_ff)
         gln_pkg::D_IDLE: begin
            if (start) begin
               mode_in   = mode;
               a_in      = op_a;
               b_in      = op_b;
               dstate_in = gln_pkg::D_SETUP;
            end
         end
         gln_pkg::D_SETUP: begin
            den_in  = ub;
            quo_in  = 64'd0;
            spec_in = 1'b0;
            smag_in = 64'd0;
            if (mode_ff == gln_pkg::DIV_Q30) begin
               neg_in = a_ff[63] ^ b_ff[63];
               rem_in = {31'd0, ua[63:31]};
               src_in = {ua[30:0], 33'd0};
               cnt_in = gln_pkg::Q30_BITS;
               if (b_ff == 64'sd0) begin
                  spec_in = 1'b1;
               end else if ({31'd0, ua} >= {ub, 31'd0}) begin
                  // integer part too large
                  spec_in = 1'b1;
                  smag_in = gln_pkg::SAT_MAG;
               end
            end else begin
               neg_in = a_ff[63];
               rem_in = 64'd0;
               src_in = {nsum[48:0], 15'd0};
               cnt_in = gln_pkg::DIVR_BITS;
            end
            dstate_in = spec_in ? gln_pkg::D_DONE : gln_pkg::D_ITER;
         end
         gln_pkg::D_ITER: begin
            rem_in = ge ? rem_sub[63:0] : rem_sh[63:0];
            quo_in = {quo_ff[62:0], ge};
            src_in = {src_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1)
               dstate_in = gln_pkg::D_DONE;
         end
         gln_pkg::D_DONE: begin
            result_in = neg_ff ? -$signed(fmag) : $signed(fmag);
            done_in   = 1'b1;
            dstate_in = gln_pkg::D_IDLE;
         end
         default: begin
            dstate_in = gln_pkg::D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= gln_pkg::D_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      src_ff    <= src_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      spec_ff   <= spec_in;
      smag_ff   <= smag_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/gauss_legendre_node_generator.sv =====
// ----------------------------------------------------------------------------
// gauss_legendre_node_generator: Gauss-Legendre nodes and weights
// Per request, finds the roots of P_n by Newton steps on the three-term
// recurrence and streams all n nodes and weights for the interval.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     node_count, lower/upper bound
//   rsp      out        rsp_valid/stall     node_index, abscissa, weight, last
//
// One request occupies the block until its last node is taken; req_stall is
// high meanwhile. Each recurrence step is one multiply and one rounded
// division, so the bit-serial divider sets the time a request takes; each
// emitted node passes through S_ORD, for the registered store read, and then
// S_OSEND. Reset is synchronous; a stalled result holds until taken.
// ----------------------------------------------------------------------------
module gauss_legendre_node_generator #(
   parameter int N_MAX      = gln_pkg::N_MAX_DEF,
   parameter int MAX_NEWTON = gln_pkg::MAX_NEWTON_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [6:0]         req_node_count,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_node_index,
   output logic signed [47:0] rsp_abscissa,
   output logic signed [47:0] rsp_weight,
   output logic               rsp_last_node
);

   localparam int AW = (N_MAX > 1) ? $clog2(N_MAX) : 1;
   localparam int IW = $clog2(MAX_NEWTON + 1);
   localparam logic [6:0] NMAX7 = 7'(N_MAX);
   localparam logic [IW-1:0] MAXIT = IW'(MAX_NEWTON);
   localparam logic [31:0] PI_Q30_L = gln_pkg::PI_Q30;

   gln_pkg::gln_state_type state_ff, state_in;
   logic               pend_ff, pend_in;
   logic [6:0]         n_ff, n_in;
   logic signed [63:0] xm_ff, xm_in, xl_ff, xl_in;
   logic [5:0]         i_ff, i_in, j_ff, j_in, out_ff, out_in;
   logic [2:0]         c_ff, c_in;
   logic [IW-1:0]      it_ff, it_in;
   logic signed [63:0] z_ff, z_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [63:0] t_ff, t_in, t2_ff, t2_in, r_ff, r_in;
   logic signed [63:0] num_ff, num_in, pp_ff, pp_in, w_ff, w_in, off_ff, off_in;

   // node store: abscissa and weight per node
   logic [95:0]   mem [N_MAX];
   logic [95:0]   rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [95:0]   mem_wd;

   // shared unit ports
   logic                      mul_start, mul_done;
   logic signed [63:0]        mul_a, mul_b, mul_res;
   logic                      div_start, div_done;
   gln_pkg::gln_div_mode_type div_mode;
   logic signed [63:0]        div_a, div_b, div_res;

   // datapath terms
   logic [6:0]         odd7, jp1;
   logic signed [55:0] rec_a, rec_b, num_p;
   logic signed [63:0] rec_v, num_v, dif, znew, zd, absc_lo, absc_hi, r_new;
   logic signed [63:0] sx1, sx2;
   logic [39:0]        th_num;
   logic [8:0]         th_den;
   logic [5:0]         hi_idx, mlast;
   logic [IW-1:0]      itn;
   logic               far, cont;

   gln_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   gln_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .mode   (div_mode),
      .op_a   (div_a),
      .op_b   (div_b),
      .done   (div_done),
      .result (div_res)
   );

   // recurrence: ((2j+1) z p_j - j p_(j-1)) before division by j+1
   assign odd7  = {j_ff, 1'b1};
   assign jp1   = {1'b0, j_ff} + 7'd1;
   assign rec_a = $signed(mul_res[47:0]) * $signed({1'b0, odd7});
   assign rec_b = $signed(p2_ff[47:0]) * $signed({2'b00, j_ff});
   assign rec_v = 64'(rec_a) - 64'(rec_b);

   // derivative numerator n (z p_n - p_(n-1))
   assign dif   = mul_res - p2_ff;
   assign num_p = $signed(dif[47:0]) * $signed({1'b0, n_ff});
   assign num_v = 64'(num_p);

   // newton update and convergence
   assign znew = gln_pkg::clamp64(z_ff - div_res, gln_pkg::ZMAX);
   assign zd   = znew - z_ff;
   assign far  = (zd > 64'sd1) || (zd < -64'sd1);
   assign itn  = it_ff + IW'(1);
   assign cont = (itn < MAXIT);

   // cosine guess terms
   assign th_num = PI_Q30_L * {2'b00, i_ff, 2'b11};
   assign th_den = {n_ff, 2'b10};
   assign r_new  = $signed({32'd0, gln_pkg::COS_COEF[c_ff]}) - mul_res;

   // mirrored node pair
   assign absc_lo = gln_pkg::clamp64(xm_ff - off_ff, gln_pkg::OUT_MAX);
   assign absc_hi = gln_pkg::clamp64(xm_ff + off_ff, gln_pkg::OUT_MAX);
   assign hi_idx  = 6'(n_ff - 7'd1 - {1'b0, i_ff});
   assign mlast   = 6'((({1'b0, n_ff} + 8'd1) >> 1) - 8'd1);

   assign sx1 = {{32{req_lower_bound[31]}}, req_lower_bound};
   assign sx2 = {{32{req_upper_bound[31]}}, req_upper_bound};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      n_in      = n_ff;
      xm_in     = xm_ff;
      xl_in     = xl_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      out_in    = out_ff;
      c_in      = c_ff;
      it_in     = it_ff;
      z_in      = z_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      t_in      = t_ff;
      t2_in     = t2_ff;
      r_in      = r_ff;
      num_in    = num_ff;
      pp_in     = pp_ff;
      w_in      = w_ff;
      off_in    = off_ff;
      mul_start = 1'b0;
      mul_a     = z_ff;
      mul_b     = p1_ff;
      div_start = 1'b0;
      div_mode  = gln_pkg::DIV_ROUND;
      div_a     = t_ff;
      div_b     = 64'sd1;
      mem_we    = 1'b0;
      mem_wa    = i_ff[AW-1:0];
      mem_wd    = {absc_lo[47:0], w_ff[47:0]};
      case (state_ff)
         gln_pkg::S_IDLE: begin
            if (req_valid && req_node_count != 7'd0) begin
               n_in     = (req_node_count > NMAX7) ? NMAX7 : req_node_count;
               xm_in    = (sx1 + sx2) <<< 13;
               xl_in    = (sx2 - sx1) <<< 13;
               i_in     = 6'd0;
               state_in = gln_pkg::S_TH;
            end
         end
         gln_pkg::S_TH: begin
            div_a = $signed({24'd0, th_num});
            div_b = $signed({55'd0, th_den});
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               t_in     = div_res;
               state_in = gln_pkg::S_T2;
            end
         end
         gln_pkg::S_T2: begin
            mul_a = t_ff;
            mul_b = t_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               r_in     = $signed({32'd0, gln_pkg::COS_COEF[6]});
               c_in     = 3'd5;
               state_in = gln_pkg::S_COS;
            end
         end
         gln_pkg::S_COS: begin
            mul_a = t2_ff;
            mul_b = r_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in = 1'b0;
               r_in    = r_new;
               if (c_ff == 3'd0) begin
                  z_in     = gln_pkg::clamp64(r_new, gln_pkg::ZMAX);
                  it_in    = '0;
                  state_in = gln_pkg::S_PINIT;
               end else begin
                  c_in = c_ff - 3'd1;
               end
            end
         end
         gln_pkg::S_PINIT: begin
            p1_in    = gln_pkg::ONE_Q30;
            p2_in    = 64'sd0;
            j_in     = 6'd0;
            state_in = gln_pkg::S_RMUL;
         end
         gln_pkg::S_RMUL: begin
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               p2_in    = p1_ff;
               t_in     = rec_v;
               state_in = gln_pkg::S_RDIV;
            end
         end
         gln_pkg::S_RDIV: begin
            div_b = $signed({57'd0, jp1});
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in = 1'b0;
               p1_in   = gln_pkg::clamp64(div_res, gln_pkg::PVAL_LIM);
               if (j_ff == 6'(n_ff - 7'd1)) begin
                  state_in = gln_pkg::S_NUM;
               end else begin
                  j_in     = j_ff + 6'd1;
                  state_in = gln_pkg::S_RMUL;
               end
            end
         end
         gln_pkg::S_NUM: begin
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               num_in   = num_v;
               state_in = gln_pkg::S_ZZ;
            end
         end
         gln_pkg::S_ZZ: begin
            mul_b = z_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               t_in     = mul_res - gln_pkg::ONE_Q30;
               state_in = gln_pkg::S_PP;
            end
         end
         gln_pkg::S_PP: begin
            div_mode = gln_pkg::DIV_Q30;
            div_a    = num_ff;
            div_b    = t_ff;
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               pp_in    = div_res;
               state_in = gln_pkg::S_DZ;
            end
         end
         gln_pkg::S_DZ: begin
            div_mode = gln_pkg::DIV_Q30;
            div_a    = p1_ff;
            div_b    = pp_ff;
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in = 1'b0;
               z_in    = znew;
               it_in   = itn;
               if (far && cont)
                  state_in = gln_pkg::S_PINIT;
               else
                  state_in = gln_pkg::S_E;
            end
         end
         gln_pkg::S_E: begin
            mul_a = num_ff;
            mul_b = pp_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               t_in     = mul_res;
               state_in = gln_pkg::S_W;
            end
         end
         gln_pkg::S_W: begin
            div_mode = gln_pkg::DIV_Q30;
            div_a    = xl_ff <<< 1;
            div_b    = -t_ff;
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               w_in     = gln_pkg::clamp64(div_res, gln_pkg::OUT_MAX);
               state_in = gln_pkg::S_OFF;
            end
         end
         gln_pkg::S_OFF: begin
            mul_a = xl_ff;
            mul_b = z_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               off_in   = mul_res;
               state_in = gln_pkg::S_WLO;
            end
         end
         gln_pkg::S_WLO: begin
            mem_we   = 1'b1;
            state_in = gln_pkg::S_WHI;
         end
         gln_pkg::S_WHI: begin
            mem_we = 1'b1;
            mem_wa = hi_idx[AW-1:0];
            mem_wd = {absc_hi[47:0], w_ff[47:0]};
            if (i_ff == mlast) begin
               out_in   = 6'd0;
               state_in = gln_pkg::S_ORD;
            end else begin
               i_in     = i_ff + 6'd1;
               state_in = gln_pkg::S_TH;
            end
         end
         gln_pkg::S_ORD: begin
            state_in = gln_pkg::S_OSEND;
         end
         gln_pkg::S_OSEND: begin
            if (!rsp_stall) begin
               if (rsp_last_node) begin
                  state_in = gln_pkg::S_IDLE;
               end else begin
                  out_in   = out_ff + 6'd1;
                  state_in = gln_pkg::S_ORD;
               end
            end
         end
         default: begin
            state_in = gln_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gln_pkg::S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      xm_ff  <= xm_in;
      xl_ff  <= xl_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      out_ff <= out_in;
      c_ff   <= c_in;
      it_ff  <= it_in;
      z_ff   <= z_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      t_ff   <= t_in;
      t2_ff  <= t2_in;
      r_ff   <= r_in;
      num_ff <= num_in;
      pp_ff  <= pp_in;
      w_ff   <= w_in;
      off_ff <= off_in;
   end

   // node store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      rd_ff <= mem[out_ff[AW-1:0]];
   end

   assign req_stall      = (state_ff != gln_pkg::S_IDLE);
   assign rsp_valid      = (state_ff == gln_pkg::S_OSEND);
   assign rsp_node_index = out_ff;
   assign rsp_abscissa   = $signed(rd_ff[95:48]);
   assign rsp_weight     = $signed(rd_ff[47:0]);
   assign rsp_last_node  = ({1'b0, out_ff} == (n_ff - 7'd1));

endmodule

// ===== dv/gauss_legendre_node_generator_test.sv =====
// ----------------------------------------------------------------------------
// gauss_legendre_node_generator_test: self-checking bench for the node generator
// Sends node requests through a table of corner cases and then random
// intervals, computes every node and weight in fixed point on the side, and
// checks each result transaction in order. Both channels idle at random, and
// the result side holds off for a long stretch once to back the block up.
// ----------------------------------------------------------------------------
module gauss_legendre_node_generator_test;

   localparam longint unsigned SAT_LIM  = 64'h4000_0000_0000_0000;
   localparam longint          UNIT_Q30 = 64'sd1073741824;
   localparam longint          ROOT_MAX = 64'sd1073741823;
   localparam longint          POLY_LIM = 64'sd1099511627776;
   localparam longint          EDGE_48  = 64'sd140737488355327;
   localparam longint unsigned PI_FIX   = 64'd3373259426;
   localparam int              COUNT_CAP  = 64;
   localparam int              NEWTON_CAP = 8;
   localparam int              RANDOM_REQS = 100;
   localparam int              HOLD_CYCLES = 3000;

   typedef struct {
      logic [5:0]         idx;
      logic signed [47:0] absc;
      logic signed [47:0] wt;
      logic               last;
   } node_type;

   typedef struct {
      logic [6:0]         count;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } request_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [6:0]         req_node_count = '0;
   logic signed [31:0] req_lower_bound = '0;
   logic signed [31:0] req_upper_bound = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1;
   logic [5:0]         rsp_node_index;
   logic signed [47:0] rsp_abscissa;
   logic signed [47:0] rsp_weight;
   logic               rsp_last_node;

   node_type node_q[$];
   int       errors = 0;
   int       reqs_taken = 0;
   int       nodes_taken = 0;
   bit       quiet = 0;   // no idling on either side
   bit       hold = 0;    // receiver holds off

   gauss_legendre_node_generator dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint signed_sat(longint unsigned m, bit neg);
      longint r;
      if (m > SAT_LIM)
         m = SAT_LIM;
      r = longint'(m);
      return neg ? -r : r;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rounded q30 product
   function automatic longint fmul(longint a, longint b);
      logic [127:0]    p;
      longint unsigned res;
      p = {64'd0, mag(a)} * {64'd0, mag(b)} + (128'd1 << 29);
      if (p[127:92] != 0)
         res = SAT_LIM;
      else
         res = p[93:30];
      return signed_sat(res, (a < 0) != (b < 0));
   endfunction

   // rounded q30 quotient, zero on a zero divisor
   function automatic longint fdiv(longint a, longint b);
      longint unsigned ua, ub;
      logic [127:0]    t;
      if (b == 0)
         return 0;
      ua = mag(a);
      ub = mag(b);
      if (ua / ub >= (64'd1 << 31))
         return signed_sat(SAT_LIM, (a < 0) != (b < 0));
      t = ({64'd0, ua} << 31) / {64'd0, ub};
      return signed_sat((t[63:0] + 1) >> 1, (a < 0) != (b < 0));
   endfunction

   function automatic longint div_small(longint v, longint d);
      return signed_sat((mag(v) + longint'(d) / 2) / longint'(d), v < 0);
   endfunction

   // taylor cosine of pi*(i+3/4)/(n+1/2)
   function automatic longint cos_start(int i, int n);
      longint unsigned a, b;
      longint th, t2, r;
      longint taylor [7] = '{1073741824, 536870912, 44739243, 1491308, 26631, 296, 2};
      a  = 4 * i + 3;
      b  = 4 * n + 2;
      th = longint'((PI_FIX * a + b / 2) / b);
      t2 = fmul(th, th);
      r  = taylor[6];
      for (int k = 5; k >= 0; k--)
         r = taylor[k] - fmul(t2, r);
      return r;
   endfunction

   task automatic predict_nodes(request_type rq);
      longint   absc [COUNT_CAP];
      longint   wts [COUNT_CAP];
      longint   x1, x2, xm, xl, z, z1, p1, p2, p3, num, pp, e, w, off;
      int       n, it;
      node_type nd;
      n = rq.count;
      if (n == 0)
         return;
      if (n > COUNT_CAP)
         n = COUNT_CAP;
      x1 = longint'(rq.lo);
      x2 = longint'(rq.hi);
      xm = (x1 + x2) * 8192;
      xl = (x2 - x1) * 8192;
      for (int i = 0; i < (n + 1) / 2; i++) begin
         z  = clip(cos_start(i, n), -ROOT_MAX, ROOT_MAX);
         it = 0;
         // newton refinement on the three-term recurrence
         do begin
            p1 = UNIT_Q30;
            p2 = 0;
            for (int j = 0; j < n; j++) begin
               p3 = p2;
               p2 = p1;
               p1 = div_small(longint'(2 * j + 1) * fmul(z, p2) - longint'(j) * p3,
                              longint'(j + 1));
               p1 = clip(p1, -POLY_LIM, POLY_LIM);
            end
            num = longint'(n) * (fmul(z, p1) - p2);
            pp  = fdiv(num, fmul(z, z) - UNIT_Q30);
            z1  = z;
            z   = clip(z1 - fdiv(p1, pp), -ROOT_MAX, ROOT_MAX);
            it++;
         end while (mag(z - z1) > 1 && it < NEWTON_CAP);
         e   = fmul(num, pp);
         w   = (e == 0) ? 0 : fdiv(2 * xl, -e);
         off = fmul(xl, z);
         absc[i]         = clip(xm - off, -EDGE_48, EDGE_48);
         absc[n - 1 - i] = clip(xm + off, -EDGE_48, EDGE_48);
         wts[i]          = clip(w, -EDGE_48, EDGE_48);
         wts[n - 1 - i]  = wts[i];
      end
      for (int k = 0; k < n; k++) begin
         nd.idx  = k[5:0];
         nd.absc = absc[k][47:0];
         nd.wt   = wts[k][47:0];
         nd.last = (k == n - 1);
         node_q.push_back(nd);
      end
   endtask

   // ---------------------------------------------------------------- monitors

   // predict on each accepted request transaction
   always @(posedge clock) begin
      request_type rq;
      if (!reset && req_valid && !req_stall) begin
         rq.count = req_node_count;
         rq.lo    = req_lower_bound;
         rq.hi    = req_upper_bound;
         predict_nodes(rq);
         reqs_taken++;
      end
   end

   // compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin
      node_type exp_nd;
      if (!reset && rsp_valid && !rsp_stall) begin
         nodes_taken++;
         if (node_q.size() == 0) begin
            errors++;
            $display("%0t unexpected node: got idx %0d absc %0d wt %0d last %0d", $time,
                     rsp_node_index, rsp_abscissa, rsp_weight, rsp_last_node);
         end else begin
            exp_nd = node_q.pop_front();
            if (rsp_node_index !== exp_nd.idx || rsp_abscissa !== exp_nd.absc ||
                rsp_weight !== exp_nd.wt || rsp_last_node !== exp_nd.last) begin
               errors++;
               $display("%0t node mismatch: expected idx %0d absc %0d wt %0d last %0d",
                        $time, exp_nd.idx, exp_nd.absc, exp_nd.wt, exp_nd.last);
               $display("%0t                got      idx %0d absc %0d wt %0d last %0d",
                        $time, rsp_node_index, rsp_abscissa, rsp_weight, rsp_last_node);
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // result side: random stalls, one long hold-off
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1;
      else if (hold)
         rsp_stall <= 1;
      else
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
   end

   initial begin
      wait (reqs_taken >= 40);
      @(negedge clock);
      hold = 1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold = 0;
   end

   task automatic send_request(request_type rq);
      while (!quiet && $urandom_range(99) < 32) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid       <= 1;
      req_node_count  <= rq.count;
      req_lower_bound <= rq.lo;
      req_upper_bound <= rq.hi;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_bound();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(8 * 65536)) - 32'sd262144;
         default: return $signed($urandom_range(65536 * 4)) - 32'sd65536;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   localparam int DIRECTED_ROWS = 14;
   localparam logic signed [31:0] BMIN = 32'sh8000_0000;
   localparam logic signed [31:0] BMAX = 32'sh7fff_ffff;

   // count, lower, upper; a zero count is expected to give no node at all
   request_type corner_rows [DIRECTED_ROWS] = '{
      '{7'd1,   32'sh0000_0000, 32'sh0001_0000},
      '{7'd2,  -32'sh0001_0000, 32'sh0001_0000},
      '{7'd3,  -32'sh0001_0000, 32'sh0001_0000},
      '{7'd0,  -32'sh0001_0000, 32'sh0001_0000},
      '{7'd4,   32'sh0000_0000, 32'sh0003_0000},
      '{7'd5,   BMIN,           BMAX},
      '{7'd4,   BMAX,           BMIN},
      '{7'd7,   32'sh0000_0064, 32'sh0000_0064},
      '{7'd6,   BMIN,           BMIN},
      '{7'd1,   BMAX,           BMAX},
      '{7'd0,   BMAX,           BMIN},
      '{7'd127, -32'sh0001_0000, 32'sh0001_0000},
      '{7'd64,  32'sh0000_0000, 32'sh0001_0000},
      '{7'd9,   32'sh5555_5555, 32'shaaaa_aaaa}
   };

   initial begin
      request_type rq;
      int          pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed corners
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_request(corner_rows[r]);

      // random requests, mostly small counts
      for (int r = 0; r < RANDOM_REQS; r++) begin
         quiet = (r >= 60 && r < 80);
         pick = $urandom_range(99);
         if (pick < 4)
            rq.count = '0;
         else if (pick < 85)
            rq.count = 7'($urandom_range(8, 1));
         else
            rq.count = 7'($urandom_range(16, 9));
         rq.lo = random_bound();
         rq.hi = (pick % 5 == 0) ? random_bound() : rq.lo + $signed($urandom_range(262144));
         send_request(rq);
      end
      quiet = 0;
      @(negedge clock);
      req_valid <= 0;

      // drain and let any trailing work settle
      wait (node_q.size() == 0);
      repeat (500) @(posedge clock);

      $display("covered %0d requests (%0d corner rows) and %0d nodes checked",
               reqs_taken, DIRECTED_ROWS, nodes_taken);
      if (errors == 0)
         $display("PASS gauss_legendre_node_generator");
      else
         $display("FAIL gauss_legendre_node_generator");
      $finish;
   end

   // run limit
   initial begin
      #(64'd8 * 64'd40_000_000);
      $display("timeout with %0d nodes outstanding", node_q.size());
      $display("FAIL gauss_legendre_node_generator");
      $finish;
   end

endmodule
